// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and reset
`define ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// same, on the clk and rst signals of the enclosing scope
`define ASSERT_STD(lbl, prop) `ASSERT_AT(lbl, clk, rst, prop)

`endif

// ===== rtl/spot_pkg.sv =====
`timescale 1ns / 1ps

package spot_pkg;

  // coordinate width; sizes are one bit narrower
  localparam int CB     = 16;
  // doubled centres and doubled edges
  localparam int CTR_W  = CB + 2;
  // centre minus clamped point
  localparam int DIFF_W = CB + 3;
  // magnitude of a distance component
  localparam int MAG_W  = CB + 2;
  localparam int SQ_W   = 2 * MAG_W;
  // radius length in doubled units (sum of two sizes)
  localparam int RAD_W  = CB;
  localparam int RSQ_W  = 2 * RAD_W;
  localparam int SUM_W  = SQ_W + 1;

  typedef enum logic [1:0] {
    PAIR_RR = 2'd0,
    PAIR_CR = 2'd1,
    PAIR_CC = 2'd2
  } pair_class_t;

  // one pair of shapes
  typedef struct packed {
    logic                 a_kind;
    logic signed [CB-1:0] a_x;
    logic signed [CB-1:0] a_y;
    logic [CB-2:0]        a_w;
    logic [CB-2:0]        a_h;
    logic                 b_kind;
    logic signed [CB-1:0] b_x;
    logic signed [CB-1:0] b_y;
    logic [CB-2:0]        b_w;
    logic [CB-2:0]        b_h;
  } in_t;

  // test result
  typedef struct packed {
    logic        overlap;
    logic [1:0]  pair_class;
  } out_t;

  // after shape decode
  typedef struct packed {
    logic                    vld;
    pair_class_t             cls;
    logic                    rr_hit;
    logic signed [CTR_W-1:0] cx;
    logic signed [CTR_W-1:0] cy;
    logic signed [CTR_W-1:0] lo_x;
    logic signed [CTR_W-1:0] hi_x;
    logic signed [CTR_W-1:0] lo_y;
    logic signed [CTR_W-1:0] hi_y;
    logic [RAD_W-1:0]        rlen;
  } s1_t;

  // after clamp
  typedef struct packed {
    logic                    vld;
    pair_class_t             cls;
    logic                    rr_hit;
    logic signed [CTR_W-1:0] cx;
    logic signed [CTR_W-1:0] cy;
    logic signed [CTR_W-1:0] tx;
    logic signed [CTR_W-1:0] ty;
    logic [RAD_W-1:0]        rlen;
  } s2_t;

  // after distance magnitude
  typedef struct packed {
    logic             vld;
    pair_class_t      cls;
    logic             rr_hit;
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
    logic [RAD_W-1:0] rlen;
  } s3_t;

  // after squaring
  typedef struct packed {
    logic             vld;
    pair_class_t      cls;
    logic             rr_hit;
    logic [SQ_W-1:0]  sqx;
    logic [SQ_W-1:0]  sqy;
    logic [RSQ_W-1:0] rsq;
  } s4_t;

endpackage

// ===== rtl/spot_front.sv =====
`timescale 1ns / 1ps

module spot_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  spot_pkg::in_t    shp,
  output spot_pkg::s2_t    s2
);

  localparam int CB    = spot_pkg::CB;
  localparam int CTR_W = spot_pkg::CTR_W;

  spot_pkg::s1_t s1;
  spot_pkg::s1_t s1_next;
  spot_pkg::s2_t s2_next;

  logic                    is_cc;
  logic                    is_rr;
  logic signed [CB-1:0]    c_x, c_y, r_x, r_y;
  logic [CB-2:0]           c_w, c_h, r_w, r_h;
  logic signed [CTR_W-1:0] r2x_lo, r2x_hi, r2x_mid;
  logic signed [CTR_W-1:0] r2y_lo, r2y_hi, r2y_mid;

  logic signed [CB:0] ax_e, ay_e, bx_e, by_e;
  logic signed [CB:0] aw_e, ah_e, bw_e, bh_e;
  logic signed [CB:0] a_rt, a_bt, b_rt, b_bt;

  logic signed [CTR_W-1:0] p_cx, p_cy, p_lox, p_hix, p_loy, p_hiy;

  // pair classification
  assign is_cc = shp.a_kind & shp.b_kind;
  assign is_rr = ~shp.a_kind & ~shp.b_kind;

  // circle side and rectangle side; A is the circle side when both are circles
  assign c_x = shp.a_kind ? shp.a_x : shp.b_x;
  assign c_y = shp.a_kind ? shp.a_y : shp.b_y;
  assign c_w = shp.a_kind ? shp.a_w : shp.b_w;
  assign c_h = shp.a_kind ? shp.a_h : shp.b_h;
  assign r_x = shp.a_kind ? shp.b_x : shp.a_x;
  assign r_y = shp.a_kind ? shp.b_y : shp.a_y;
  assign r_w = shp.a_kind ? shp.b_w : shp.a_w;
  assign r_h = shp.a_kind ? shp.b_h : shp.a_h;

  // doubled rectangle extents and doubled centre of the other shape
  assign r2x_lo  = {r_x[CB-1], r_x, 1'b0};
  assign r2x_hi  = r2x_lo + {2'b00, r_w, 1'b0};
  assign r2x_mid = r2x_lo + {3'b000, r_w};
  assign r2y_lo  = {r_y[CB-1], r_y, 1'b0};
  assign r2y_hi  = r2y_lo + {2'b00, r_h, 1'b0};
  assign r2y_mid = r2y_lo + {3'b000, r_h};

  // rectangle against rectangle, edges touching count
  assign ax_e = {shp.a_x[CB-1], shp.a_x};
  assign ay_e = {shp.a_y[CB-1], shp.a_y};
  assign bx_e = {shp.b_x[CB-1], shp.b_x};
  assign by_e = {shp.b_y[CB-1], shp.b_y};
  assign aw_e = {2'b00, shp.a_w};
  assign ah_e = {2'b00, shp.a_h};
  assign bw_e = {2'b00, shp.b_w};
  assign bh_e = {2'b00, shp.b_h};
  assign a_rt = ax_e + aw_e;
  assign a_bt = ay_e + ah_e;
  assign b_rt = bx_e + bw_e;
  assign b_bt = by_e + bh_e;

  // stage 1: decode
  always_comb begin
    s1_next.vld    = in_vld;
    if (is_cc) begin
      s1_next.cls = spot_pkg::PAIR_CC;
    end else if (is_rr) begin
      s1_next.cls = spot_pkg::PAIR_RR;
    end else begin
      s1_next.cls = spot_pkg::PAIR_CR;
    end
    s1_next.rr_hit = !((a_bt < by_e) || (ay_e > b_bt) ||
                       (a_rt < bx_e) || (ax_e > b_rt));
    s1_next.cx     = {c_x[CB-1], c_x, 1'b0} + {3'b000, c_w};
    s1_next.cy     = {c_y[CB-1], c_y, 1'b0} + {3'b000, c_h};
    // a second circle clamps to its own centre: both bounds at that point
    s1_next.lo_x   = is_cc ? r2x_mid : r2x_lo;
    s1_next.hi_x   = is_cc ? r2x_mid : r2x_hi;
    s1_next.lo_y   = is_cc ? r2y_mid : r2y_lo;
    s1_next.hi_y   = is_cc ? r2y_mid : r2y_hi;
    s1_next.rlen   = is_cc ? ({1'b0, shp.a_w} + {1'b0, shp.b_w}) : {1'b0, c_w};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1 <= s1_next;
    end
  end

  // stage 2: clamp the centre into the box
  assign p_cx  = s1.cx;
  assign p_cy  = s1.cy;
  assign p_lox = s1.lo_x;
  assign p_hix = s1.hi_x;
  assign p_loy = s1.lo_y;
  assign p_hiy = s1.hi_y;

  always_comb begin
    s2_next.vld    = s1.vld;
    s2_next.cls    = s1.cls;
    s2_next.rr_hit = s1.rr_hit;
    s2_next.cx     = p_cx;
    s2_next.cy     = p_cy;
    s2_next.tx     = (p_cx < p_lox) ? p_lox : ((p_cx > p_hix) ? p_hix : p_cx);
    s2_next.ty     = (p_cy < p_loy) ? p_loy : ((p_cy > p_hiy) ? p_hiy : p_cy);
    s2_next.rlen   = s1.rlen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else begin
      s2 <= s2_next;
    end
  end

endmodule

// ===== rtl/spot_square.sv =====
`timescale 1ns / 1ps

module spot_square (
  input  logic          clk,
  input  logic          rst,
  input  spot_pkg::s2_t s2,
  output spot_pkg::s4_t s4
);

  localparam int CTR_W  = spot_pkg::CTR_W;
  localparam int DIFF_W = spot_pkg::DIFF_W;
  localparam int MAG_W  = spot_pkg::MAG_W;
  localparam int SQ_W   = spot_pkg::SQ_W;
  localparam int RSQ_W  = spot_pkg::RSQ_W;

  spot_pkg::s3_t s3;
  spot_pkg::s3_t s3_next;
  spot_pkg::s4_t s4_next;

  logic signed [CTR_W-1:0]  cx, cy, tx, ty;
  logic signed [DIFF_W-1:0] dx, dy, ndx, ndy;

  assign cx = s2.cx;
  assign cy = s2.cy;
  assign tx = s2.tx;
  assign ty = s2.ty;

  // stage 3: distance components and their magnitudes
  assign dx  = {cx[CTR_W-1], cx} - {tx[CTR_W-1], tx};
  assign dy  = {cy[CTR_W-1], cy} - {ty[CTR_W-1], ty};
  assign ndx = -dx;
  assign ndy = -dy;

  always_comb begin
    s3_next.vld    = s2.vld;
    s3_next.cls    = s2.cls;
    s3_next.rr_hit = s2.rr_hit;
    s3_next.mx     = dx[DIFF_W-1] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
    s3_next.my     = dy[DIFF_W-1] ? ndy[MAG_W-1:0] : dy[MAG_W-1:0];
    s3_next.rlen   = s2.rlen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3 <= '0;
    end else begin
      s3 <= s3_next;
    end
  end

  // stage 4: squares
  always_comb begin
    s4_next.vld    = s3.vld;
    s4_next.cls    = s3.cls;
    s4_next.rr_hit = s3.rr_hit;
    s4_next.sqx    = SQ_W'(s3.mx) * SQ_W'(s3.mx);
    s4_next.sqy    = SQ_W'(s3.my) * SQ_W'(s3.my);
    s4_next.rsq    = RSQ_W'(s3.rlen) * RSQ_W'(s3.rlen);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4 <= '0;
    end else begin
      s4 <= s4_next;
    end
  end

endmodule

// ===== rtl/spot_decide.sv =====
`timescale 1ns / 1ps

module spot_decide (
  input  logic           clk,
  input  logic           rst,
  input  spot_pkg::s4_t  s4,
  output logic           done,
  output spot_pkg::out_t result
);

  localparam int SUM_W = spot_pkg::SUM_W;

  logic [SUM_W-1:0] d2;
  logic [SUM_W-1:0] r2;
  logic             hit;
  spot_pkg::out_t   result_next;

  // stage 5: squared distance against squared radius, strict; rect-rect pairs use rr_hit
  assign d2 = {1'b0, s4.sqx} + {1'b0, s4.sqy};
  assign r2 = SUM_W'(s4.rsq);
  assign hit = (s4.cls == spot_pkg::PAIR_RR) ? s4.rr_hit : (d2 < r2);

  always_comb begin
    result_next.overlap    = hit;
    result_next.pair_class = s4.cls;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4.vld;
    end
  end

endmodule

// ===== rtl/shape_pair_overlap_test_top.sv =====
`timescale 1ns / 1ps

// result strobed on done after registers s1, s2, s3, s4 and the result register (one per pipeline stage)
// throughput: one transaction per cycle; busy stays low, the five-stage pipeline never stalls
// results appear for one cycle only, the receiver cannot hold them off
// reset: synchronous, active high; clears the stage valid bits, in-flight transactions are dropped
module shape_pair_overlap_test_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  spot_pkg::in_t  shapes,
  output logic           done,
  output spot_pkg::out_t result
);

  spot_pkg::s2_t s2;
  spot_pkg::s4_t s4;
  logic          accept;

  // every cycle can take a new pair
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // shape decode and clamp
  spot_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_vld (accept),
    .shp    (shapes),
    .s2     (s2)
  );

  // distance magnitudes and squares
  spot_square u_square (
    .clk (clk),
    .rst (rst),
    .s2  (s2),
    .s4  (s4)
  );

  // final compare and result register
  spot_decide u_decide (
    .clk    (clk),
    .rst    (rst),
    .s4     (s4),
    .done   (done),
    .result (result)
  );

endmodule

// ===== rtl/spot_chk.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module spot_chk (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input spot_pkg::in_t  shapes,
  input logic           done,
  input spot_pkg::out_t result
);

  // every accepted transaction yields a result on done
  `ASSERT_STD(a_done_follows, (start && !busy) |-> ##5 done)

  // no result without an earlier accepted transaction
  `ASSERT_STD(a_done_has_cause, done |-> $past(start && !busy, 5))

  // pair class follows the two shape kinds of the same transaction
  `ASSERT_STD(a_class_match, (start && !busy) |-> ##5
    ((result.pair_class[1] == $past(shapes.a_kind & shapes.b_kind, 5)) &&
     (result.pair_class[0] == $past(shapes.a_kind ^ shapes.b_kind, 5))))

endmodule

bind shape_pair_overlap_test_top spot_chk u_spot_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .shapes (shapes),
  .done   (done),
  .result (result)
);

// ===== verif/shape_pair_overlap_test_top_tb.sv =====
`timescale 1ns / 1ps

module shape_pair_overlap_test_top_tb;

  localparam logic KIND_RECT   = 1'b0;
  localparam logic KIND_CIRCLE = 1'b1;
  localparam int   CYCLE_LIMIT = 100000;
  localparam int   RANDOM_PAIRS = 550;
  localparam int   DRAIN_CYCLES = 8;

  typedef struct {
    spot_pkg::in_t  pair;
    bit             typed;
    spot_pkg::out_t want;
  } probe_t;

  typedef struct {
    spot_pkg::in_t  pair;
    spot_pkg::out_t want;
  } verdict_t;

  logic           clk   = 1'b0;
  logic           rst   = 1'b1;
  logic           start = 1'b0;
  spot_pkg::in_t  shapes = '0;
  logic           busy;
  logic           done;
  spot_pkg::out_t result;

  verdict_t       verdicts_due[$];
  int             errors = 0;
  int             cycle_count = 0;
  int             idle_pct = 0;
  bit             next_typed = 1'b0;
  spot_pkg::out_t next_want = '0;
  int             class_count[3] = '{0, 0, 0};
  int             hit_count = 0;

  // clock
  always #10 clk = ~clk;

  shape_pair_overlap_test_top u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .shapes (shapes),
    .done   (done),
    .result (result)
  );

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // expected overlap verdict; circle distances in doubled coordinates, rect-rect edges in plain ones
  function automatic spot_pkg::out_t overlap_of(spot_pkg::in_t p);
    longint         ax, ay, aw, ah, bx, by, bw, bh;
    longint         cx, cy, cw, ch, rx, ry, rw, rh, dx, dy;
    spot_pkg::out_t r;
    ax = longint'(p.a_x);
    ay = longint'(p.a_y);
    aw = longint'(p.a_w);
    ah = longint'(p.a_h);
    bx = longint'(p.b_x);
    by = longint'(p.b_y);
    bw = longint'(p.b_w);
    bh = longint'(p.b_h);
    if (p.a_kind == KIND_RECT && p.b_kind == KIND_RECT) begin
      // interval test, touching edges count
      r.pair_class = spot_pkg::PAIR_RR;
      r.overlap = !((ay + ah < by) || (ay > by + bh) ||
                    (ax + aw < bx) || (ax > bx + bw));
    end else if (p.a_kind == KIND_CIRCLE && p.b_kind == KIND_CIRCLE) begin
      dx = (2 * ax + aw) - (2 * bx + bw);
      dy = (2 * ay + ah) - (2 * by + bh);
      r.pair_class = spot_pkg::PAIR_CC;
      r.overlap = (dx * dx + dy * dy) < (aw + bw) * (aw + bw);
    end else begin
      if (p.a_kind == KIND_CIRCLE) begin
        cx = ax; cy = ay; cw = aw; ch = ah;
        rx = bx; ry = by; rw = bw; rh = bh;
      end else begin
        cx = bx; cy = by; cw = bw; ch = bh;
        rx = ax; ry = ay; rw = aw; rh = ah;
      end
      // centre minus its clamp into the box
      dx = (2 * cx + cw) - clamp_to(2 * cx + cw, 2 * rx, 2 * rx + 2 * rw);
      dy = (2 * cy + ch) - clamp_to(2 * cy + ch, 2 * ry, 2 * ry + 2 * rh);
      r.pair_class = spot_pkg::PAIR_CR;
      r.overlap = (dx * dx + dy * dy) < cw * cw;
    end
    return r;
  endfunction

  function automatic spot_pkg::in_t pair_of(logic ak, int ax, int ay, int aw, int ah,
                                            logic bk, int bx, int by, int bw, int bh);
    spot_pkg::in_t p;
    p.a_kind = ak;
    p.a_x = 16'(ax);
    p.a_y = 16'(ay);
    p.a_w = 15'(aw);
    p.a_h = 15'(ah);
    p.b_kind = bk;
    p.b_x = 16'(bx);
    p.b_y = 16'(by);
    p.b_w = 15'(bw);
    p.b_h = 15'(bh);
    return p;
  endfunction

  function automatic probe_t directed_row(spot_pkg::in_t p, bit typed, bit ov,
                                          spot_pkg::pair_class_t cls);
    probe_t row;
    row.pair = p;
    row.typed = typed;
    row.want.overlap = ov;
    row.want.pair_class = cls;
    return row;
  endfunction

  // coordinate near one end of the signed range
  function automatic int near_rail();
    return $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 63))
                                : -32768 + int'($urandom_range(0, 63));
  endfunction

  // size near zero or near full scale
  function automatic int near_rail_size();
    return $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 63))
                                : int'($urandom_range(0, 63));
  endfunction

  // mix of raw random pairs, clustered pairs that often meet, and pairs at the rails
  function automatic spot_pkg::in_t random_pair();
    int            mode;
    int            x0;
    int            y0;
    spot_pkg::in_t p;
    mode = $urandom_range(0, 99);
    p.a_kind = 1'($urandom_range(0, 1));
    p.b_kind = 1'($urandom_range(0, 1));
    if (mode < 25) begin
      p.a_x = 16'($urandom);
      p.a_y = 16'($urandom);
      p.a_w = 15'($urandom);
      p.a_h = 15'($urandom);
      p.b_x = 16'($urandom);
      p.b_y = 16'($urandom);
      p.b_w = 15'($urandom);
      p.b_h = 15'($urandom);
    end else if (mode < 85) begin
      x0 = int'($urandom_range(0, 60000)) - 30000;
      y0 = int'($urandom_range(0, 60000)) - 30000;
      p.a_x = 16'(x0 + int'($urandom_range(0, 1023)) - 512);
      p.a_y = 16'(y0 + int'($urandom_range(0, 1023)) - 512);
      p.b_x = 16'(x0 + int'($urandom_range(0, 1023)) - 512);
      p.b_y = 16'(y0 + int'($urandom_range(0, 1023)) - 512);
      p.a_w = ($urandom_range(0, 9) == 0) ? 15'd0 : 15'($urandom_range(0, 1023));
      p.a_h = ($urandom_range(0, 9) == 0) ? 15'd0 : 15'($urandom_range(0, 1023));
      p.b_w = ($urandom_range(0, 9) == 0) ? 15'd0 : 15'($urandom_range(0, 1023));
      p.b_h = ($urandom_range(0, 9) == 0) ? 15'd0 : 15'($urandom_range(0, 1023));
      // round circles half of the time
      if (p.a_kind == KIND_CIRCLE && $urandom_range(0, 1)) p.a_h = p.a_w;
      if (p.b_kind == KIND_CIRCLE && $urandom_range(0, 1)) p.b_h = p.b_w;
    end else begin
      p.a_x = 16'(near_rail());
      p.a_y = 16'(near_rail());
      p.a_w = 15'(near_rail_size());
      p.a_h = 15'(near_rail_size());
      p.b_x = 16'(near_rail());
      p.b_y = 16'(near_rail());
      p.b_w = 15'(near_rail_size());
      p.b_h = 15'(near_rail_size());
    end
    return p;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // one transaction: random idle cycles, then hold start until accepted
  task automatic send_pair(spot_pkg::in_t p, bit typed, spot_pkg::out_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      shapes = random_pair();
      @(negedge clk);
    end
    start = 1'b1;
    shapes = p;
    next_typed = typed;
    next_want = want;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    start = 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
  endtask

  // result checking and transaction capture
  always @(posedge clk) begin : monitor
    verdict_t       v;
    spot_pkg::out_t model;
    if (!rst) begin
      if (done) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing due: overlap=%0b class=%0d",
                                    result.overlap, result.pair_class));
        end else begin
          v = verdicts_due.pop_front();
          if (result.overlap !== v.want.overlap)
            report_mismatch($sformatf("overlap %0b, want %0b, pair %h",
                                      result.overlap, v.want.overlap, v.pair));
          if (result.pair_class !== v.want.pair_class)
            report_mismatch($sformatf("pair_class %0d, want %0d, pair %h",
                                      result.pair_class, v.want.pair_class, v.pair));
        end
      end
      if (start && !busy) begin
        model = overlap_of(shapes);
        v.pair = shapes;
        v.want = next_typed ? next_want : model;
        verdicts_due.push_back(v);
        class_count[model.pair_class]++;
        if (model.overlap) hit_count++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("shape_pair_overlap_test_top regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    probe_t probes[$];
    int     phase_pct[3];
    phase_pct = '{32, 83, 0};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // rect-rect
    probes.push_back(directed_row(pair_of(KIND_RECT, 0, 0, 32, 32,
                                          KIND_RECT, 16, 16, 32, 32),
                                  1'b1, 1'b1, spot_pkg::PAIR_RR));
    probes.push_back(directed_row(pair_of(KIND_RECT, 0, 0, 16, 16,
                                          KIND_RECT, 16, 0, 16, 16),
                                  1'b1, 1'b1, spot_pkg::PAIR_RR));
    probes.push_back(directed_row(pair_of(KIND_RECT, 0, 0, 16, 16,
                                          KIND_RECT, 17, 0, 16, 16),
                                  1'b1, 1'b0, spot_pkg::PAIR_RR));
    probes.push_back(directed_row(pair_of(KIND_RECT, 0, 0, 16, 16,
                                          KIND_RECT, 0, 17, 16, 16),
                                  1'b1, 1'b0, spot_pkg::PAIR_RR));
    probes.push_back(directed_row(pair_of(KIND_RECT, -32768, -32768, 32767, 32767,
                                          KIND_RECT, 32767, 32767, 32767, 32767),
                                  1'b1, 1'b0, spot_pkg::PAIR_RR));
    probes.push_back(directed_row(pair_of(KIND_RECT, -32768, -32768, 32767, 32767,
                                          KIND_RECT, -100, -100, 0, 0),
                                  1'b1, 1'b1, spot_pkg::PAIR_RR));
    probes.push_back(directed_row(pair_of(KIND_RECT, 5, 5, 0, 0,
                                          KIND_RECT, 5, 5, 0, 0),
                                  1'b1, 1'b1, spot_pkg::PAIR_RR));
    // circle-circle, including touching and zero radius
    probes.push_back(directed_row(pair_of(KIND_CIRCLE, 0, 0, 32, 32,
                                          KIND_CIRCLE, 31, 0, 32, 32),
                                  1'b1, 1'b1, spot_pkg::PAIR_CC));
    probes.push_back(directed_row(pair_of(KIND_CIRCLE, 0, 0, 32, 32,
                                          KIND_CIRCLE, 32, 0, 32, 32),
                                  1'b1, 1'b0, spot_pkg::PAIR_CC));
    probes.push_back(directed_row(pair_of(KIND_CIRCLE, 0, 0, 0, 0,
                                          KIND_CIRCLE, 0, 0, 0, 0),
                                  1'b1, 1'b0, spot_pkg::PAIR_CC));
    probes.push_back(directed_row(pair_of(KIND_CIRCLE, 0, 0, 0, 0,
                                          KIND_CIRCLE, -16, -16, 32, 32),
                                  1'b1, 1'b1, spot_pkg::PAIR_CC));
    probes.push_back(directed_row(pair_of(KIND_CIRCLE, -32768, -32768, 32767, 32767,
                                          KIND_CIRCLE, -32768, -32768, 32767, 32767),
                                  1'b1, 1'b1, spot_pkg::PAIR_CC));
    probes.push_back(directed_row(pair_of(KIND_CIRCLE, -32768, -32768, 32767, 32767,
                                          KIND_CIRCLE, 32767, 32767, 32767, 32767),
                                  1'b0, 1'b0, spot_pkg::PAIR_CC));
    probes.push_back(directed_row(pair_of(KIND_CIRCLE, 0, 0, 32, 64,
                                          KIND_CIRCLE, 0, 40, 32, 0),
                                  1'b0, 1'b0, spot_pkg::PAIR_CC));
    // circle-rect both ways round, touching, zero radius, centre placed by height
    probes.push_back(directed_row(pair_of(KIND_CIRCLE, 32, 0, 32, 32,
                                          KIND_RECT, 0, 0, 32, 32),
                                  1'b1, 1'b0, spot_pkg::PAIR_CR));
    probes.push_back(directed_row(pair_of(KIND_RECT, 0, 0, 32, 32,
                                          KIND_CIRCLE, 31, 0, 32, 32),
                                  1'b1, 1'b1, spot_pkg::PAIR_CR));
    probes.push_back(directed_row(pair_of(KIND_CIRCLE, 10, 10, 0, 0,
                                          KIND_RECT, 0, 0, 32, 32),
                                  1'b1, 1'b0, spot_pkg::PAIR_CR));
    probes.push_back(directed_row(pair_of(KIND_CIRCLE, 0, 0, 32, 160,
                                          KIND_RECT, 0, 80, 32, 32),
                                  1'b1, 1'b1, spot_pkg::PAIR_CR));
    probes.push_back(directed_row(pair_of(KIND_CIRCLE, 0, 0, 32, 32,
                                          KIND_RECT, 0, 80, 32, 32),
                                  1'b1, 1'b0, spot_pkg::PAIR_CR));
    probes.push_back(directed_row(pair_of(KIND_RECT, 16, 16, 0, 0,
                                          KIND_CIRCLE, 0, 0, 32, 32),
                                  1'b1, 1'b1, spot_pkg::PAIR_CR));
    probes.push_back(directed_row(pair_of(KIND_CIRCLE, 0, 0, 32, 32,
                                          KIND_RECT, 26, 26, 16, 16),
                                  1'b1, 1'b1, spot_pkg::PAIR_CR));
    probes.push_back(directed_row(pair_of(KIND_CIRCLE, 0, 0, 32, 32,
                                          KIND_RECT, 28, 28, 16, 16),
                                  1'b1, 1'b0, spot_pkg::PAIR_CR));
    probes.push_back(directed_row(pair_of(KIND_CIRCLE, 32767, 32767, 32767, 32767,
                                          KIND_RECT, -32768, -32768, 32767, 32767),
                                  1'b0, 1'b0, spot_pkg::PAIR_CR));
    probes.push_back(directed_row(pair_of(KIND_RECT, -32768, 32767, 32767, 0,
                                          KIND_CIRCLE, 32767, -32768, 0, 32767),
                                  1'b0, 1'b0, spot_pkg::PAIR_CR));

    // directed table
    idle_pct = phase_pct[0];
    foreach (probes[i]) send_pair(probes[i].pair, probes[i].typed, probes[i].want);

    // random pairs in three idle phases, fully drained between phases
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = phase_pct[ph];
      if (ph != 0) hold_until_drained();
      repeat (RANDOM_PAIRS / 3) send_pair(random_pair(), 1'b0, '0);
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d shape pairs: %0d rect-rect, %0d circle-rect, %0d circle-circle",
             class_count[0] + class_count[1] + class_count[2],
             class_count[0], class_count[1], class_count[2]);
    $display("%0d pairs overlapped, %0d mismatches", hit_count, errors);
    if (errors == 0) begin
      $display("shape_pair_overlap_test_top regression: pass");
    end else begin
      $display("shape_pair_overlap_test_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/spot_pkg.sv
rtl/spot_front.sv
rtl/spot_square.sv
rtl/spot_decide.sv
rtl/shape_pair_overlap_test_top.sv
rtl/spot_chk.sv
verif/shape_pair_overlap_test_top_tb.sv
